[sv/pcps_pkg.sv]
package pcps_pkg;

  localparam int MAX_SECTORS  = 16;
  localparam int SECT_IDX_W   = $clog2(MAX_SECTORS);
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 44;
  localparam int SQRT_STEPS   = 15;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic [15:0] OUTSIDE_COLOR = 16'hFFFF;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_SECTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECTION_ACTIVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_RADIUS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_BORDER_WIDTH = 3'd7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // search token handed from cell to cell
  typedef struct packed {
    logic                  vld;
    logic                  found;
    logic [SECT_IDX_W-1:0] hit;
    logic [15:0]           fill;
    logic [15:0]           border;
  } srch_t;

  // atan(2^-i) as a 32-bit turn fraction
  function automatic logic [31:0] step_turn(input logic [STEP_W-1:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      5'd24: t = 32'd41;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd3;
      5'd29: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

[sv/pcps_if.sv]
interface pcps_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  sector_index;
  logic [16:0] end_angle;
  logic [15:0] inside_color;
  logic [15:0] edge_color;
  logic [9:0]  pixel_x;
  logic [7:0]  pixel_y;
  modport source (output valid, opcode, sector_index, end_angle, inside_color, edge_color,
                  pixel_x, pixel_y, input ready);
  modport sink (input valid, opcode, sector_index, end_angle, inside_color, edge_color,
                pixel_x, pixel_y, output ready);
endinterface

interface pcps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;
  logic [3:0]  hit_sector;
  modport source (output valid, pixel_color, hit_sector, input ready);
  modport sink (input valid, pixel_color, hit_sector, output ready);
endinterface

interface pcps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/pcps_cell.sv]
module pcps_cell import pcps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SECT_IDX_W-1:0] cell_idx_i,
  input  logic [SECT_IDX_W-1:0] last_idx_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  input  logic                  we_i,
  input  logic [SECT_IDX_W-1:0] wr_idx_i,
  input  logic [ANGLE_BITS:0]   wr_angle_i,
  input  logic [15:0]           wr_fill_i,
  input  logic [15:0]           wr_border_i,
  input  srch_t                 tok_i,
  output srch_t                 tok_o
);

  logic [ANGLE_BITS:0] end_q;
  logic [15:0]         fill_q;
  logic [15:0]         border_q;
  srch_t               tok_d, tok_q;

  always_ff @(posedge clk_i) begin
    if (we_i && wr_idx_i == cell_idx_i) begin
      end_q    <= wr_angle_i;
      fill_q   <= wr_fill_i;
      border_q <= wr_border_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.found &&
        (({1'b0, angle_i} < end_q) || cell_idx_i == last_idx_i)) begin
      tok_d.found  = 1'b1;
      tok_d.hit    = cell_idx_i;
      tok_d.fill   = fill_q;
      tok_d.border = border_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[sv/pcps_polar.sv]
module pcps_polar import pcps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [10:0]    dx_i,
  input  logic signed [8:0]     dy_i,
  output logic                  done_o,
  output logic [14:0]           dist_o,
  output logic [ANGLE_BITS-1:0] angle_o
);

  logic                       busy_q, done_q;
  logic [STEP_W-1:0]          cnt_q;
  logic [29:0]                rem_q, root_q;
  logic signed [CORDIC_W-1:0] vx_q, vy_q;
  logic [31:0]                acc_q;

  logic signed [21:0]         dx_sq;
  logic signed [17:0]         dy_sq;
  logic [21:0]                sum_sq;
  logic signed [CORDIC_W-1:0] vx0, vy0;
  logic [4:0]                 sq_sh;
  logic [29:0]                sq_bit, sq_trial;
  logic signed [CORDIC_W-1:0] vx_sh, vy_sh;

  always_comb begin
    dx_sq    = dx_i * dx_i;
    dy_sq    = dy_i * dy_i;
    sum_sq   = 22'(dx_sq) + 22'(dy_sq);
    vx0      = {{5{dy_i[8]}}, dy_i, 30'b0};
    vy0      = {{3{dx_i[10]}}, dx_i, 30'b0};
    sq_sh    = 5'd28 - {cnt_q[3:0], 1'b0};
    sq_bit   = 30'(1) << sq_sh;
    sq_trial = root_q + sq_bit;
    vx_sh    = vx_q >>> cnt_q;
    vy_sh    = vy_q >>> cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {sum_sq[20:0], 9'b0} >> 1;
      root_q <= '0;
      if (dy_i < 0) begin
        vx_q  <= -vx0;
        vy_q  <= -vy0;
        acc_q <= 32'h8000_0000;
      end else begin
        vx_q  <= vx0;
        vy_q  <= vy0;
        acc_q <= '0;
      end
    end else if (busy_q) begin
      // bit-pair square root
      if (cnt_q < STEP_W'(SQRT_STEPS)) begin
        if (rem_q >= sq_trial) begin
          rem_q  <= rem_q - sq_trial;
          root_q <= (root_q >> 1) + sq_bit;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      // vectoring rotation, idle once the residual is zero
      if (vy_q > 0) begin
        vx_q  <= vx_q + vy_sh;
        vy_q  <= vy_q - vx_sh;
        acc_q <= acc_q + step_turn(cnt_q);
      end else if (vy_q < 0) begin
        vx_q  <= vx_q - vy_sh;
        vy_q  <= vy_q + vx_sh;
        acc_q <= acc_q - step_turn(cnt_q);
      end
    end
  end

  assign done_o  = done_q;
  assign dist_o  = root_q[14:0];
  assign angle_o = acc_q[31:32-ANGLE_BITS];

endmodule

[sv/pie_chart_pixel_shader.sv]
// a load transaction gives no result; a pixel transaction gives its result after
// 30 cordic steps (the square root runs alongside), a pass through the sector cell
// chain, and an 8-step alpha divider when the pixel lies in an edge band;
// one pixel at a time
// reset: asynchronous, clears control and restores all configuration defaults;
// the sector table stays undefined until loaded
module pie_chart_pixel_shader import pcps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcps_in_if.sink      in_ch_i,
  pcps_out_if.source   out_ch_o,
  pcps_cfg_if.sink     cfg_ch_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_POLAR, ST_SEARCH, ST_CLASS, ST_DIV, ST_BLEND, ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [4:0]  sector_count_q;
  logic [3:0]  selected_sector_q;
  logic        selection_active_q;
  logic [9:0]  center_x_q;
  logic [7:0]  center_y_q;
  logic [13:0] ring_radius_q;
  logic [9:0]  border_width_q;
  logic [9:0]  sel_border_width_q;

  // per-pixel working registers
  logic signed [10:0] dx_q;
  logic signed [8:0]  dy_q;
  logic [3:0]         hit_q;
  logic [15:0]        fill_q, border_q, first_q, color_q;
  logic [9:0]         rem_q;
  logic [7:0]         num_lo_q, quot_q;
  logic [2:0]         div_cnt_q;
  logic [9:0]         bw_q;

  logic               out_vld_q;
  logic [15:0]        out_color_q;
  logic [3:0]         out_hit_q;

  logic in_acc, cfg_acc, load_we;
  assign in_acc  = in_ch_i.valid && in_ch_i.ready;
  assign cfg_acc = cfg_ch_i.valid && cfg_ch_i.ready;
  assign load_we = in_acc && in_ch_i.opcode == OP_LOAD;

  assign in_ch_i.ready  = (state_q == ST_IDLE);
  assign cfg_ch_i.ready = 1'b1;

  // polar conversion unit
  logic                  polar_done;
  logic [14:0]           ring_dist;
  logic [ANGLE_BITS-1:0] angle;

  pcps_polar u_polar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .done_o  (polar_done),
    .dist_o  (ring_dist),
    .angle_o (angle)
  );

  // sector search: a token walks the cell chain, one cell per cycle
  logic [SECT_IDX_W-1:0] last_idx;
  srch_t                 chain [MAX_SECTORS+1];

  always_comb begin
    if (sector_count_q == '0) begin
      last_idx = '0;
    end else if (sector_count_q > 5'(MAX_SECTORS)) begin
      last_idx = SECT_IDX_W'(MAX_SECTORS - 1);
    end else begin
      last_idx = SECT_IDX_W'(sector_count_q - 1'b1);
    end
  end

  always_comb begin
    chain[0]     = '0;
    chain[0].vld = (state_q == ST_POLAR) && polar_done;
  end

  for (genvar k = 0; k < MAX_SECTORS; k++) begin : g_cell
    pcps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (SECT_IDX_W'(k)),
      .last_idx_i  (last_idx),
      .angle_i     (angle),
      .we_i        (load_we),
      .wr_idx_i    (in_ch_i.sector_index),
      .wr_angle_i  (in_ch_i.end_angle),
      .wr_fill_i   (in_ch_i.inside_color),
      .wr_border_i (in_ch_i.edge_color),
      .tok_i       (chain[k]),
      .tok_o       (chain[k+1])
    );
  end

  // ring classification
  logic [9:0]         bw, inner;
  logic               selected;
  logic signed [16:0] to_ring, neg_ring, e_full;
  logic [10:0]        fill_lim;
  logic [9:0]         e;
  logic [17:0]        num;
  logic [10:0]        div_trial;

  always_comb begin
    bw       = (border_width_q == '0) ? 10'd1 : border_width_q;
    selected = selection_active_q && hit_q == selected_sector_q;
    inner    = (selected && sel_border_width_q > bw) ? sel_border_width_q - bw : '0;
    to_ring  = $signed({2'b0, ring_dist}) - $signed({3'b0, ring_radius_q});
    neg_ring = -to_ring;
    fill_lim = {1'b0, inner} + {1'b0, bw};
    e_full   = (to_ring >= 0) ? to_ring : neg_ring - $signed({7'b0, inner});
    e        = e_full[9:0];
    num      = {e, 8'b0} - {8'b0, e};
    div_trial = {rem_q, num_lo_q[7]};
  end

  function automatic logic [15:0] blend565(input logic [15:0] a, input logic [15:0] b,
                                           input logic [7:0] alpha);
    logic [7:0]  inv;
    logic [16:0] r, g, bl;
    inv = 8'd255 - alpha;
    r   = 17'({a[15:11], 3'b0} * alpha) + 17'({b[15:11], 3'b0} * inv);
    g   = 17'({a[10:5], 2'b0} * alpha) + 17'({b[10:5], 2'b0} * inv);
    bl  = 17'({a[4:0], 3'b0} * alpha) + 17'({b[4:0], 3'b0} * inv);
    return {r[15:11], g[15:10], bl[15:11]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      out_vld_q          <= 1'b0;
      sector_count_q     <= 5'd1;
      selected_sector_q  <= 4'd0;
      selection_active_q <= 1'b1;
      center_x_q         <= 10'd160;
      center_y_q         <= 8'd74;
      ring_radius_q      <= 14'd1056;
      border_width_q     <= 10'd16;
      sel_border_width_q <= 10'd48;
      div_cnt_q          <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_ch_i.index)
          CFG_SECTOR_COUNT:     sector_count_q     <= cfg_ch_i.data[4:0];
          CFG_SELECTED_SECTOR:  selected_sector_q  <= cfg_ch_i.data[3:0];
          CFG_SELECTION_ACTIVE: selection_active_q <= cfg_ch_i.data[0];
          CFG_CENTER_X:         center_x_q         <= cfg_ch_i.data[9:0];
          CFG_CENTER_Y:         center_y_q         <= cfg_ch_i.data[7:0];
          CFG_RING_RADIUS:      ring_radius_q      <= cfg_ch_i.data;
          CFG_BORDER_WIDTH:     border_width_q     <= cfg_ch_i.data[9:0];
          CFG_SEL_BORDER_WIDTH: sel_border_width_q <= cfg_ch_i.data[9:0];
          default: ;
        endcase
      end

      // output register: load a finished pixel, else drop a taken result
      if (state_q == ST_DONE && (!out_vld_q || out_ch_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_ch_i.opcode == OP_PIXEL) begin
            state_q <= ST_START;
          end
        end
        ST_START: state_q <= ST_POLAR;
        ST_POLAR: begin
          if (polar_done) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (chain[MAX_SECTORS].vld) begin
            state_q <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (to_ring >= $signed({7'b0, bw})) begin
            state_q <= ST_DONE;
          end else if (neg_ring > $signed({6'b0, fill_lim})) begin
            state_q <= ST_DONE;
          end else if (to_ring < 0 && neg_ring < $signed({7'b0, inner})) begin
            state_q <= ST_DONE;
          end else begin
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 3'd7) begin
            state_q <= ST_BLEND;
          end
        end
        ST_BLEND: state_q <= ST_DONE;
        ST_DONE: begin
          // result waits here only while the output register is full and not being taken
          if (!out_vld_q || out_ch_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dx_q <= $signed({1'b0, in_ch_i.pixel_x}) - $signed({1'b0, center_x_q});
        dy_q <= $signed({1'b0, center_y_q}) - $signed({1'b0, in_ch_i.pixel_y});
      end
      ST_SEARCH: begin
        hit_q    <= chain[MAX_SECTORS].hit;
        fill_q   <= chain[MAX_SECTORS].fill;
        border_q <= chain[MAX_SECTORS].border;
      end
      ST_CLASS: begin
        bw_q     <= bw;
        rem_q    <= num[17:8];
        num_lo_q <= num[7:0];
        first_q  <= (to_ring < 0) ? fill_q : OUTSIDE_COLOR;
        if (to_ring >= $signed({7'b0, bw})) begin
          color_q <= OUTSIDE_COLOR;
        end else if (neg_ring > $signed({6'b0, fill_lim})) begin
          color_q <= fill_q;
        end else begin
          color_q <= border_q;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        num_lo_q <= {num_lo_q[6:0], 1'b0};
        if (div_trial >= {1'b0, bw_q}) begin
          rem_q  <= 10'(div_trial - {1'b0, bw_q});
          quot_q <= {quot_q[6:0], 1'b1};
        end else begin
          rem_q  <= div_trial[9:0];
          quot_q <= {quot_q[6:0], 1'b0};
        end
      end
      ST_BLEND: color_q <= blend565(first_q, border_q, quot_q);
      ST_DONE: begin
        if (!out_vld_q || out_ch_o.ready) begin
          out_color_q <= color_q;
          out_hit_q   <= hit_q;
        end
      end
      default: ;
    endcase
  end

  assign out_ch_o.valid       = out_vld_q;
  assign out_ch_o.pixel_color = out_color_q;
  assign out_ch_o.hit_sector  = out_hit_q;

endmodule

[sv/pcps_checker.sv]
module pcps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        opcode_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] pixel_color_i,
  input logic [3:0]  hit_sector_i
);

  // a waiting result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_color_i)
                                    && $stable(hit_sector_i))
    else $error("output changed while stalled");

  // a pixel occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && opcode_i |=> !in_ready_i)
    else $error("transaction accepted while a pixel is in flight");

  // a load produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !opcode_i && !out_valid_i |=> !out_valid_i)
    else $error("load transaction produced a result");

  // no result right after a pixel enters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && opcode_i |=> !$rose(out_valid_i))
    else $error("result too early");

endmodule

bind pie_chart_pixel_shader pcps_checker u_pcps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch_i.valid),
  .in_ready_i    (in_ch_i.ready),
  .opcode_i      (in_ch_i.opcode),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .pixel_color_i (out_ch_o.pixel_color),
  .hit_sector_i  (out_ch_o.hit_sector)
);
